/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rstn, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)

`define ASSERT_IMPLIES(lbl, clk, rstn, cond, expr, msg)

`endif

`endif

/* hdl/fares_pkg.sv */
// ----------------------------------------------------------------------------
// fares_pkg
// Types, constants and helpers of the fractional audio resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package fares_pkg;

    typedef logic signed [15:0] sample_t;
    typedef logic signed [57:0] wide_t;

    localparam logic [1:0] MODE_PASS    = 2'd0;
    localparam logic [1:0] MODE_LINEAR  = 2'd1;
    localparam logic [1:0] MODE_CUBIC   = 2'd2;
    localparam logic [1:0] MODE_LANCZOS = 2'd3;

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_STEP = 1'b1;

    localparam logic [20:0] ONE_Q16  = 21'd65536;
    localparam logic [20:0] STEP_MIN = 21'd8192;
    localparam logic [20:0] STEP_MAX = 21'd1048576;
    localparam int          MAX_OUT  = 40;

    // saturate to the signed 16-bit range
    function automatic sample_t sat16(input wide_t v);
        sample_t r;
        if (v > 58'sd32767)
            r = 16'sh7fff;
        else if (v < -58'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    // arithmetic shift right, rounding toward zero
    function automatic wide_t shr_trunc(input wide_t v, input int unsigned s);
        wide_t r;
        if (v[57])
            r = -((-v) >>> s);
        else
            r = v >>> s;
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/fares_divider.sv */
// ----------------------------------------------------------------------------
// fares_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fares_divider #(
    parameter int NUM_W = 36,
    parameter int DEN_W = 20
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, q_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract where it fits
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            q_reg   <= {q_reg[NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

/* hdl/fractional_audio_resampler_unit.sv */
// ----------------------------------------------------------------------------
// fractional_audio_resampler_unit
// Fractional-rate resampler: pass-through, linear, cubic or Lanczos
// interpolation over a short sample history, one shared multiplier.
// ----------------------------------------------------------------------------
//
//  Channel   | Handshake              | Payload
//  ----------+------------------------+-------------------------------------
//  s_axis    | tvalid / tready        | tdata = sample_in, tlast = last_in
//  m_axis    | tvalid / tready        | tdata = sample_out, tlast = last_out
//  cfg       | cfg_we (no wait)       | cfg_addr 0 mode, 1 phase_step
//
//  One input transaction is taken only in the idle state; the block then
//  works alone until all its outputs are handed to the output register.
//  Per output, pass-through takes the centre tap, linear and cubic fetch
//  four taps and work through the shared multiplier, and Lanczos sends
//  nine taps through the multiplier, then a 36-bit restoring divider.
//  Each input transaction adds accept, end check, end decision and
//  hand-off steps, and a drain adds a step for each centre walked.
//  A stalled output holds the sequencer where the next output must go out.
//  Reset is asynchronous; the weight table is a constant, so no fill pass.
`default_nettype none

`include "assert_macros.svh"

module fractional_audio_resampler_unit
    import fares_pkg::*;
#(
    parameter int HALF_WIDTH = 4,
    parameter int PHASES     = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] sample_in
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] sample_out
    output logic             m_axis_tlast,
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [20:0] cfg_data
);

    localparam int HIST   = 2 * HALF_WIDTH + 1;
    localparam int IDX_W  = $clog2(HIST);
    localparam int VC_W   = $clog2(HIST + 1);
    localparam int D_W    = $clog2(HALF_WIDTH + 1);
    localparam int CNT_W  = $clog2(HIST + 2);
    localparam int N_W    = $clog2(MAX_OUT + 1);
    localparam int P_W    = $clog2(PHASES);
    localparam int TAB_N  = PHASES * HIST;
    localparam int TAB_W  = $clog2(TAB_N);
    localparam longint Q30     = 64'sd1073741824;
    localparam longint PI_Q30  = 64'sd3373259426;
    localparam longint SpanDen = HALF_WIDTH * PHASES;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_FETCH = 4'd2;
    localparam logic [3:0] S_MATH  = 4'd3;
    localparam logic [3:0] S_LZ    = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_RES   = 4'd6;
    localparam logic [3:0] S_ENDD  = 4'd7;
    localparam logic [3:0] S_DSTEP = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    typedef logic signed [16:0] weight_t;
    typedef weight_t wtab_t [TAB_N];

    // ------------------------------------------------------------------
    // Lanczos weight table, worked out at elaboration in Q30 integers
    // ------------------------------------------------------------------

    // truncating division, long-hand, for the table build only
    function automatic longint div_trunc(input longint a, input longint b);
        longint ua;
        longint ub;
        longint q;
        longint r;
        logic   neg;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        q   = 0;
        r   = 0;
        for (int i = 62; i >= 0; i--)
        begin
            r = (r <<< 1) | ((ua >>> i) & 64'sd1);
            q = q <<< 1;
            if (r >= ub)
            begin
                r = r - ub;
                q = q | 64'sd1;
            end
        end
        return neg ? -q : q;
    endfunction

    function automatic longint sin_pi(input longint m, input logic wide);
        longint n;
        longint x;
        longint x2;
        longint r;
        logic   neg;
        neg = m < 0;
        n   = neg ? -m : m;
        if (wide)
        begin
            n = n - div_trunc(n, 2 * SpanDen) * (2 * SpanDen);
            if (n >= SpanDen)
            begin
                n   = n - SpanDen;
                neg = !neg;
            end
            if (2 * n > SpanDen)
                n = SpanDen - n;
            x = div_trunc(PI_Q30 * n, SpanDen);
        end
        else
        begin
            n = n - div_trunc(n, 2 * PHASES) * (2 * PHASES);
            if (n >= PHASES)
            begin
                n   = n - PHASES;
                neg = !neg;
            end
            if (2 * n > PHASES)
                n = PHASES - n;
            x = div_trunc(PI_Q30 * n, PHASES);
        end
        x2 = (x * x) >>> 30;
        r  = Q30;
        r  = Q30 - ((x2 * r) >>> 30) / 110;
        r  = Q30 - ((x2 * r) >>> 30) / 72;
        r  = Q30 - ((x2 * r) >>> 30) / 42;
        r  = Q30 - ((x2 * r) >>> 30) / 20;
        r  = Q30 - ((x2 * r) >>> 30) / 6;
        r  = (x * r) >>> 30;
        return neg ? -r : r;
    endfunction

    function automatic longint sinc_q30(input longint m, input logic wide);
        longint theta;
        longint r;
        if (m == 0)
            r = Q30;
        else
        begin
            theta = wide ? div_trunc(PI_Q30 * m, SpanDen) : div_trunc(PI_Q30 * m, PHASES);
            r     = div_trunc(sin_pi(m, wide) * Q30, theta);
        end
        return r;
    endfunction

    function automatic wtab_t build_wtab();
        wtab_t  t;
        longint m;
        longint am;
        longint f;
        for (int p = 0; p < PHASES; p++)
        begin
            for (int i = -HALF_WIDTH; i <= HALF_WIDTH; i++)
            begin
                m  = longint'(p) - longint'(i) * PHASES;
                am = (m < 0) ? -m : m;
                t[p * HIST + i + HALF_WIDTH] = '0;
                if (am < SpanDen)
                begin
                    f = sinc_q30(m, 1'b0) * sinc_q30(m, 1'b1);
                    t[p * HIST + i + HALF_WIDTH] = 17'((f + (64'sd1 <<< 44)) >>> 45);
                end
            end
        end
        return t;
    endfunction

    localparam wtab_t WTAB = build_wtab();

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    sample_t              hist_reg [HIST];
    logic [VC_W-1:0]      vc_reg;
    logic [20:0]          phase_reg;
    logic [1:0]           mode_reg;
    logic [20:0]          step_reg;
    logic [3:0]           state_reg;
    logic [D_W-1:0]       d_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [N_W-1:0]       n_reg;
    logic                 last_reg;
    logic                 drain_reg;
    logic                 started_reg;
    sample_t              c_reg [4];
    logic signed [56:0]   prod_reg;
    logic signed [35:0]   mac_reg;
    logic signed [19:0]   ws_reg;
    weight_t              lz_w_reg;
    logic                 lz_en_reg;
    logic                 neg_reg;
    sample_t              y_next;
    logic                 y_ready;
    sample_t              y_hold;
    sample_t              pend_reg;
    logic                 pend_valid_reg;
    logic                 out_valid_reg;
    sample_t              out_data_reg;
    logic                 out_last_reg;
    logic                 out_load;

    logic                 in_fire;
    logic [20:0]          eff_step;
    logic [20:0]          phase_nc;
    logic [VC_W-1:0]      vc_next;
    logic [15:0]          frac;
    logic signed [16:0]   fz;
    logic [P_W-1:0]       lz_p;
    logic [IDX_W-1:0]     tap_k;
    logic                 tap_en;
    sample_t              tap_s;
    weight_t              tab_w;
    logic signed [39:0]   mul_a;
    logic signed [16:0]   mul_b;
    logic signed [56:0]   mul_p;
    logic signed [20:0]   cu_a0;
    logic signed [21:0]   cu_a1;
    logic signed [16:0]   cu_a2;
    logic signed [39:0]   cu_u;
    wide_t                cu_v;
    wide_t                fin_t;
    logic                 div_start;
    logic                 div_done;
    logic [35:0]          div_quot;
    logic [35:0]          mac_mag;
    logic signed [37:0]   q_signed;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign frac    = phase_reg[15:0];
    assign fz      = signed'({1'b0, frac});
    assign lz_p    = P_W'((32'(frac) * PHASES) >> 16);

    always_comb
    begin
        if (step_reg < STEP_MIN)
            eff_step = STEP_MIN;
        else if (step_reg > STEP_MAX)
            eff_step = STEP_MAX;
        else
            eff_step = step_reg;
    end

    // move the read position to the next centre
    assign phase_nc = (phase_reg[20:16] != '0) ? phase_reg - ONE_Q16 : '0;
    assign vc_next  = (vc_reg >= VC_W'(HIST)) ? VC_W'(HIST) : vc_reg + 1'b1;

    // ------------------------------------------------------------------
    // Tap select: one history read per cycle, edge-clamped or masked
    // ------------------------------------------------------------------
    always_comb
    begin
        int k;
        int off;
        k      = 0;
        tap_en = 1'b0;
        off    = 0;
        unique case (state_reg)
            S_FETCH: off = int'(cnt_reg) - 1;
            S_LZ:    off = int'(cnt_reg) - HALF_WIDTH;
            default: off = 0;
        endcase
        k = int'(d_reg) - off;
        tap_en = (state_reg == S_LZ) && (int'(cnt_reg) < HIST) && (k >= 0)
                 && (k < int'(vc_reg)) && (k < HIST);
        if (state_reg != S_LZ && k >= int'(vc_reg))
            k = int'(vc_reg) - 1;
        if (k < 0)
            k = 0;
        if (k >= HIST)
            k = HIST - 1;
        tap_k = IDX_W'(k);
    end

    assign tap_s = hist_reg[tap_k];
    assign tab_w = (int'(cnt_reg) < HIST)
                   ? WTAB[TAB_W'(int'(lz_p) * HIST + int'(cnt_reg))] : '0;

    // cubic coefficients from the four fetched taps
    assign cu_a0 = -21'(c_reg[0]) + 21'(c_reg[1]) * 21'sd3
                   - 21'(c_reg[2]) * 21'sd3 + 21'(c_reg[3]);
    assign cu_a1 = 22'(c_reg[0]) * 22'sd2 - 22'(c_reg[1]) * 22'sd5
                   + 22'(c_reg[2]) * 22'sd4 - 22'(c_reg[3]);
    assign cu_a2 = 17'(c_reg[2]) - 17'(c_reg[0]);
    assign cu_u  = 40'(prod_reg) + (40'(cu_a1) <<< 16);
    assign cu_v  = 58'(prod_reg) + (58'(cu_a2) <<< 32);

    // ------------------------------------------------------------------
    // Shared multiplier operand select
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MATH:
            begin
                mul_b = fz;
                if (mode_reg == MODE_LINEAR)
                    mul_a = 40'(17'(c_reg[2]) - 17'(c_reg[1]));
                else
                begin
                    case (cnt_reg)
                        CNT_W'(0): mul_a = 40'(cu_a0);
                        CNT_W'(1): mul_a = cu_u;
                        default:   mul_a = 40'(cu_v >>> 16);
                    endcase
                end
            end
            S_LZ:
            begin
                mul_a = 40'(tap_s);
                mul_b = tab_w;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 57'(mul_a * mul_b);

    // final add for linear and cubic
    assign fin_t = (mode_reg == MODE_LINEAR)
                   ? 58'(prod_reg) + (58'(c_reg[1]) <<< 16)
                   : 58'(prod_reg) + (58'(c_reg[1]) <<< 33);

    assign mac_mag  = mac_reg[35] ? 36'(-mac_reg) : 36'(mac_reg);
    assign q_signed = neg_reg ? -38'(div_quot) : 38'(div_quot);

    // result of the current output, valid when y_ready
    always_comb
    begin
        y_next  = '0;
        y_ready = 1'b0;
        unique case (state_reg)
            S_CHECK:
            begin
                y_next  = tap_s;
                y_ready = (phase_reg[20:16] == '0) && (mode_reg == MODE_PASS);
            end
            S_MATH:
            begin
                if (mode_reg == MODE_LINEAR)
                begin
                    y_next  = sat16(shr_trunc(fin_t, 16));
                    y_ready = cnt_reg == CNT_W'(1);
                end
                else
                begin
                    y_next  = sat16(shr_trunc(fin_t, 33));
                    y_ready = cnt_reg == CNT_W'(3);
                end
            end
            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    y_next  = sat16(shr_trunc(58'(mac_reg), 15));
                    y_ready = ws_reg[19] || (ws_reg == '0);
                end
                else
                begin
                    y_next  = sat16(58'(q_signed));
                    y_ready = div_done;
                end
            end
            default:
            begin
                y_next  = '0;
                y_ready = 1'b0;
            end
        endcase
    end

    assign div_start = (state_reg == S_DIV) && (cnt_reg == '0) && !y_ready;

    fares_divider #(
        .NUM_W (36),
        .DEN_W (20)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mac_mag),
        .den   (20'(ws_reg)),
        .done  (div_done),
        .quot  (div_quot)
    );

    // hand the pending result to the output register this cycle
    assign out_load = pend_valid_reg && !out_valid_reg
                      && (((state_reg == S_RES) && (n_reg < N_W'(MAX_OUT)))
                          || (state_reg == S_FIN));

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_LANCZOS;
            step_reg <= ONE_Q16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_MODE: mode_reg <= cfg_data[1:0];
                CFG_STEP: step_reg <= cfg_data;
                default:  mode_reg <= mode_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            vc_reg         <= '0;
            phase_reg      <= '0;
            d_reg          <= '0;
            cnt_reg        <= '0;
            n_reg          <= '0;
            last_reg       <= 1'b0;
            drain_reg      <= 1'b0;
            started_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < HIST; i++)
                hist_reg[i] <= '0;
        end
        else
        begin
            // drop the output once the sink takes it
            if (m_axis_tready && !out_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        for (int i = HIST - 1; i > 0; i--)
                            hist_reg[i] <= hist_reg[i-1];
                        hist_reg[0] <= s_axis_tdata;
                        vc_reg      <= vc_next;
                        last_reg    <= s_axis_tlast;
                        drain_reg   <= 1'b0;
                        n_reg       <= '0;
                        d_reg       <= D_W'(HALF_WIDTH);
                        if (vc_next > VC_W'(HALF_WIDTH))
                        begin
                            if (vc_reg > VC_W'(HALF_WIDTH))
                                phase_reg <= phase_nc;
                            state_reg <= S_CHECK;
                        end
                        else
                            state_reg <= S_ENDD;
                    end
                end

                S_CHECK:
                begin
                    cnt_reg <= '0;
                    mac_reg <= '0;
                    ws_reg  <= '0;
                    if (phase_reg[20:16] != '0)
                        state_reg <= S_ENDD;
                    else
                    begin
                        unique case (mode_reg) inside
                            MODE_PASS:    state_reg <= S_RES;
                            MODE_LINEAR,
                            MODE_CUBIC:   state_reg <= S_FETCH;
                            MODE_LANCZOS: state_reg <= S_LZ;
                            default:      state_reg <= S_RES;
                        endcase
                    end
                end

                S_FETCH:
                begin
                    c_reg[cnt_reg[1:0]] <= tap_s;
                    if (cnt_reg == CNT_W'(3))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_MATH;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end

                S_MATH:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (y_ready)
                        state_reg <= S_RES;
                end

                S_LZ:
                begin
                    // multiply this tap, accumulate the one before
                    lz_w_reg  <= tab_w;
                    lz_en_reg <= tap_en;
                    if (cnt_reg != '0 && lz_en_reg)
                    begin
                        mac_reg <= mac_reg + prod_reg[35:0];
                        ws_reg  <= ws_reg + 20'(lz_w_reg);
                    end
                    if (cnt_reg == CNT_W'(HIST))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end

                S_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        neg_reg <= mac_reg[35];
                        cnt_reg <= CNT_W'(1);
                    end
                    if (y_ready)
                        state_reg <= S_RES;
                end

                S_RES:
                begin
                    if (n_reg >= N_W'(MAX_OUT))
                    begin
                        phase_reg <= phase_reg + eff_step;
                        state_reg <= S_CHECK;
                    end
                    else if (!(pend_valid_reg && out_valid_reg))
                    begin
                        // the older result is not the last one: release it
                        if (pend_valid_reg)
                        begin
                            out_data_reg  <= pend_reg;
                            out_last_reg  <= 1'b0;
                            out_valid_reg <= 1'b1;
                        end
                        pend_valid_reg <= 1'b1;
                        n_reg          <= n_reg + 1'b1;
                        phase_reg      <= phase_reg + eff_step;
                        state_reg      <= S_CHECK;
                    end
                end

                S_ENDD:
                begin
                    if (!drain_reg)
                    begin
                        if (last_reg)
                        begin
                            drain_reg   <= 1'b1;
                            started_reg <= vc_reg > VC_W'(HALF_WIDTH);
                            d_reg       <= (vc_reg > VC_W'(HALF_WIDTH))
                                           ? D_W'(HALF_WIDTH - 1)
                                           : D_W'(vc_reg - 1'b1);
                            state_reg   <= S_DSTEP;
                        end
                        else
                            state_reg <= S_FIN;
                    end
                    else if (d_reg == '0)
                        state_reg <= S_FIN;
                    else
                    begin
                        d_reg     <= d_reg - 1'b1;
                        state_reg <= S_DSTEP;
                    end
                end

                S_DSTEP:
                begin
                    if (started_reg)
                        phase_reg <= phase_nc;
                    started_reg <= 1'b1;
                    state_reg   <= S_CHECK;
                end

                S_FIN:
                begin
                    if (!(pend_valid_reg && out_valid_reg))
                    begin
                        if (pend_valid_reg)
                        begin
                            out_data_reg  <= pend_reg;
                            out_last_reg  <= last_reg;
                            out_valid_reg <= 1'b1;
                        end
                        pend_valid_reg <= 1'b0;
                        if (last_reg)
                        begin
                            phase_reg <= '0;
                            vc_reg    <= '0;
                            for (int i = 0; i < HIST; i++)
                                hist_reg[i] <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // result payload: hold the newest result until the next one shows up
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (state_reg == S_RES && n_reg < N_W'(MAX_OUT)
            && !(pend_valid_reg && out_valid_reg))
            pend_reg <= y_hold;
        if (y_ready)
            y_hold <= y_next;
    end

    assign s_axis_tready = state_reg == S_IDLE;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_cap, clk, rst_n, n_reg <= N_W'(MAX_OUT), "output count past cap")
    `ASSERT_ALWAYS(a_vc, clk, rst_n, vc_reg <= VC_W'(HIST), "history count past depth")
    `ASSERT_IMPLIES(a_res_pos, clk, rst_n, state_reg == S_RES, phase_reg[20:16] == '0,
                    "result taken with read position past the centre")
    `ASSERT_IMPLIES(a_div_own, clk, rst_n, div_done, state_reg == S_DIV,
                    "divider finished outside the division step")

endmodule

`default_nettype wire
